// ===== rtl/s2da_pkg.sv =====
// Package for the signed integer to decimal ASCII converter.
// Holds the word type passed along the digit cells, ASCII codes and place weights.
// No dependencies.
package s2da_pkg;

  localparam int unsigned NumCells = 4;
  localparam int unsigned MaxChars = 6;

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_MINUS = 8'd45;

  typedef struct packed {
    logic                           neg;
    logic [15:0]                    rem;
    logic [NumCells-1:0][3:0]       digits;
  } s2da_word_t;

  function automatic logic [16:0] place_weight(logic [1:0] place);
    logic [16:0] w;
    unique case (place)
      2'd0:    w = 17'd10000;
      2'd1:    w = 17'd1000;
      2'd2:    w = 17'd100;
      default: w = 17'd10;
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/s2da_digit_cell.sv =====
// One decimal place of the conversion chain: extracts a digit and passes the remainder on.
// Depends on s2da_pkg.
module s2da_digit_cell import s2da_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] place,
  input  logic       up_valid,
  input  s2da_word_t up_word,
  output logic       up_stall,
  output logic       dn_valid,
  output s2da_word_t dn_word,
  input  logic       dn_stall
);

  logic       valid_r;
  s2da_word_t word_r;
  s2da_word_t word_nxt;
  logic [3:0] digit;
  logic [16:0] weight;

  assign weight = place_weight(place);

  always_comb begin
    logic [16:0] thr;
    digit = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      thr = 17'(k) * weight;
      if ({1'b0, up_word.rem} >= thr) begin
        digit = 4'(k);
      end
    end
    word_nxt = up_word;
    word_nxt.rem = 16'({1'b0, up_word.rem} - 17'(digit) * weight);
    word_nxt.digits[place] = digit;
  end

  assign up_stall = valid_r & dn_stall;
  assign dn_valid = valid_r;
  assign dn_word  = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_valid && !up_stall) begin
      valid_r <= 1'b1;
    end else if (!dn_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && !up_stall) begin
      word_r <= word_nxt;
    end
  end

endmodule

// ===== rtl/s2da_char_shifter.sv =====
// Output stage: loads the characters of one number and shifts them out one per word.
// Depends on s2da_pkg.
module s2da_char_shifter import s2da_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       up_valid,
  input  s2da_word_t up_word,
  output logic       up_stall,
  output logic       out_valid,
  output logic [7:0] out_text_byte,
  output logic       out_last_char,
  input  logic       out_stall
);

  logic [MaxChars-1:0][7:0] chars_r;
  logic [MaxChars-1:0][7:0] chars_nxt;
  logic [2:0]               count_r;
  logic [2:0]               count_nxt;
  logic [MaxChars-1:0][7:0] load_chars;
  logic                     load;
  logic                     fire;

  assign out_valid     = count_r != 3'd0;
  assign out_text_byte = chars_r[0];
  assign out_last_char = count_r == 3'd1;
  assign fire          = out_valid && !out_stall;
  assign up_stall      = (count_r > 3'd1) || ((count_r == 3'd1) && out_stall);
  assign load          = up_valid && !up_stall;

  always_comb begin
    logic [4:0][7:0] dig;
    for (int i = 0; i < NumCells; i++) begin
      dig[i] = ASCII_ZERO + {4'd0, up_word.digits[i]};
    end
    dig[NumCells] = ASCII_ZERO + {4'd0, up_word.rem[3:0]};
    if (up_word.neg) begin
      load_chars[0] = ASCII_MINUS;
      for (int i = 0; i < 5; i++) begin
        load_chars[i+1] = dig[i];
      end
    end else begin
      for (int i = 0; i < 5; i++) begin
        load_chars[i] = dig[i];
      end
      load_chars[5] = ASCII_ZERO;
    end
  end

  always_comb begin
    chars_nxt = chars_r;
    count_nxt = count_r;
    if (load) begin
      chars_nxt = load_chars;
      count_nxt = up_word.neg ? 3'd6 : 3'd5;
    end else if (fire) begin
      for (int i = 0; i < MaxChars - 1; i++) begin
        chars_nxt[i] = chars_r[i+1];
      end
      count_nxt = count_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 3'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chars_r <= chars_nxt;
  end

endmodule

// ===== rtl/signed_int_to_decimal_ascii.sv =====
// Top level of the signed 16-bit integer to decimal ASCII converter.
// Depends on s2da_pkg, s2da_digit_cell and s2da_char_shifter.
//
// Usage:
// The input channel (in_valid, in_value, in_stall) takes one signed 16-bit
// word. The output channel (out_valid, out_text_byte, out_last_char,
// out_stall) returns its decimal text one character per word: a minus sign
// for negative values, then five digits with leading zeros, the last of
// which carries out_last_char. The value -32768 prints as -32768.
// Four digit cells, one per place from ten thousands down to tens, form a
// chain that moves one number a cycle unless stalled; the units digit is the remainder.
// The first character appears once the word has passed the four digit cells
// and been loaded into the output stage, which sends five or six characters
// per number, one per cycle unless the receiver stalls, and takes the next
// number as its last character goes out; the cells hold up to four more meanwhile.
// When the receiver stalls, the current character holds and the chain
// fills, after which in_stall rises. Reset empties the chain and the
// output stage; no character is pending afterwards.
module signed_int_to_decimal_ascii import s2da_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [15:0] in_value,
  output logic        in_stall,
  output logic        out_valid,
  output logic [7:0]  out_text_byte,
  output logic        out_last_char,
  input  logic        out_stall
);

  s2da_word_t          in_word;
  s2da_word_t          link_word  [NumCells+1];
  logic [NumCells:0]   link_valid;
  logic [NumCells:0]   link_stall;

  always_comb begin
    in_word.neg    = in_value[15];
    in_word.rem    = in_value[15] ? 16'(~in_value + 16'd1) : in_value;
    in_word.digits = '0;
  end

  assign link_word[0]  = in_word;
  assign link_valid[0] = in_valid;
  assign in_stall      = link_stall[0];

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    s2da_digit_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .place    (2'(i)),
      .up_valid (link_valid[i]),
      .up_word  (link_word[i]),
      .up_stall (link_stall[i]),
      .dn_valid (link_valid[i+1]),
      .dn_word  (link_word[i+1]),
      .dn_stall (link_stall[i+1])
    );
  end

  s2da_char_shifter u_shifter (
    .clk           (clk),
    .rst_n         (rst_n),
    .up_valid      (link_valid[NumCells]),
    .up_word       (link_word[NumCells]),
    .up_stall      (link_stall[NumCells]),
    .out_valid     (out_valid),
    .out_text_byte (out_text_byte),
    .out_last_char (out_last_char),
    .out_stall     (out_stall)
  );

endmodule
